FILE: rtl/core/pot_scanline_timer_io_assert.svh
// Assertion macros shared by the checker of the scanline timer block.
`ifndef POT_SCANLINE_TIMER_IO_ASSERT_SVH
`define POT_SCANLINE_TIMER_IO_ASSERT_SVH

// Clocked check that is switched off while reset is held.
`define PSTIO_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also runs while reset is held.
`define PSTIO_ASSERT_RST(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/core/pstio_pkg.sv
// ----------------------------------------------------------------------------
// pstio_pkg
// Constants and codes for the scanline pot timer and input block.
// ----------------------------------------------------------------------------
package pstio_pkg;

    localparam int LINES_PER_FRAME = 262;
    localparam int IRQ_LINE_STEP   = 64;

    localparam int LINE_W  = 9;
    localparam int PHASE_W = $clog2(IRQ_LINE_STEP + 1);
    localparam int NUM_POTS = 6;

    localparam logic [LINE_W-1:0]  LINE_LAST  = LINE_W'(LINES_PER_FRAME - 1);
    localparam logic [PHASE_W-1:0] PHASE_LAST = PHASE_W'(IRQ_LINE_STEP - 1);
    localparam logic [PHASE_W-1:0] PHASE_RST  =
        PHASE_W'((LINES_PER_FRAME - 1) % IRQ_LINE_STEP);

    // Operation codes of an input request.
    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_WRITE = 2'd2;

    // Configuration register indexes.
    localparam logic [1:0] CFG_ROUNDS  = 2'd0;
    localparam logic [1:0] CFG_COINAGE = 2'd1;
    localparam logic [1:0] CFG_ROUND_T = 2'd2;

    // Misc read selects, from the low two address bits.
    localparam logic [1:0] MISC_POTS    = 2'd0;
    localparam logic [1:0] MISC_LINE    = 2'd1;
    localparam logic [1:0] MISC_ROUNDS  = 2'd2;
    localparam logic [1:0] MISC_COINAGE = 2'd3;

    localparam logic [13:0] ADDR_POT_LATCH = 14'h1800;
    localparam logic [7:0]  READ_XOR       = 8'h3f;

endpackage

FILE: rtl/core/pot_scanline_timer_io.sv
// ----------------------------------------------------------------------------
// pot_scanline_timer_io: scanline pot timer, interrupt and input read block.
// The result follows in the next cycle; one request a cycle while not stalled.
// The rate is set by the single update of the state and the result register.
// Synchronous active-low reset: line 261, all flags, latches and samples clear.
// ----------------------------------------------------------------------------
module pot_scanline_timer_io (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration write port.
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [7:0]  i_cfg_data,
    // Request channel.
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_op,
    input  logic [13:0] i_address,
    input  logic [7:0]  i_write_data,
    input  logic [7:0]  i_stick_a_x,
    input  logic [7:0]  i_stick_a_y,
    input  logic [7:0]  i_paddle_a,
    input  logic [7:0]  i_stick_b_x,
    input  logic [7:0]  i_stick_b_y,
    input  logic [7:0]  i_paddle_b,
    input  logic [7:0]  i_switches,
    // Result channel.
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [7:0]  o_read_data,
    output logic        o_irq_level,
    output logic        o_nmi_level,
    output logic [8:0]  o_line_now
);

    // Configuration registers.
    logic [1:0] r_rounds;
    logic [1:0] r_coinage;
    logic [7:0] r_round_time;

    // Timer and interrupt state.
    logic [pstio_pkg::LINE_W-1:0]   r_line,   n_line;
    logic [pstio_pkg::PHASE_W-1:0]  r_phase,  n_phase;
    logic [7:0]                     r_pot [pstio_pkg::NUM_POTS];
    logic [pstio_pkg::NUM_POTS-1:0] r_crossed, n_crossed;
    logic [pstio_pkg::NUM_POTS-1:0] r_latch,   n_latch;
    logic                           r_irq,    n_irq;
    logic                           r_nmi,    n_nmi;

    // Result register.
    logic       r_out_valid;
    logic [7:0] r_read_data, n_read_data;

    logic                           accept;
    logic                           sample_pots;
    logic [7:0]                     pot_in [pstio_pkg::NUM_POTS];
    logic [pstio_pkg::NUM_POTS-1:0] hits;
    logic [7:0]                     sw_val;
    logic [7:0]                     misc_val;

    // The result register frees up in the same cycle it is taken, so a new
    // request is held back only while a result sits there unclaimed.
    assign o_in_stall = r_out_valid & i_out_stall;
    assign accept     = i_in_valid & ~o_in_stall;

    assign pot_in[0] = i_stick_a_x;
    assign pot_in[1] = i_stick_a_y;
    assign pot_in[2] = i_paddle_a;
    assign pot_in[3] = i_stick_b_x;
    assign pot_in[4] = i_stick_b_y;
    assign pot_in[5] = i_paddle_b;

    // Line advance for a tick. The IRQ phase counter runs alongside the line
    // and restarts at line zero, so IRQ fires on each multiple of the step.
    always_comb begin
        if (r_line == pstio_pkg::LINE_LAST) begin
            n_line  = '0;
            n_phase = '0;
        end else begin
            n_line  = r_line + 1'b1;
            n_phase = (r_phase == pstio_pkg::PHASE_LAST) ? '0 : r_phase + 1'b1;
        end
    end

    assign sample_pots = (n_line == '0);

    // Pot crossings only happen on lines 1 to 255. A sampled pot of zero can
    // never match, since line zero is excluded.
    always_comb begin
        for (int i = 0; i < pstio_pkg::NUM_POTS; i++) begin
            hits[i] = (n_line[8] == 1'b0) && (n_line != '0) && (r_pot[i] == n_line[7:0]);
        end
    end

    // Switch read: bit one is ORed with the round-time flag.
    always_comb begin
        sw_val    = i_switches;
        sw_val[1] = i_switches[1] | (r_line > {1'b0, r_round_time});
    end

    always_comb begin
        case (i_address[1:0])
            pstio_pkg::MISC_POTS:    misc_val = {2'b00, r_crossed & r_latch};
            pstio_pkg::MISC_LINE:    misc_val = r_line[7:0];
            pstio_pkg::MISC_ROUNDS:  misc_val = {6'b0, r_rounds};
            pstio_pkg::MISC_COINAGE: misc_val = {6'b0, r_coinage};
            default:                 misc_val = '0;
        endcase
    end

    // Next state and result of one request.
    always_comb begin
        n_crossed   = r_crossed;
        n_latch     = r_latch;
        n_irq       = r_irq;
        n_nmi       = r_nmi;
        n_read_data = '0;
        case (i_op)
            pstio_pkg::OP_TICK: begin
                if (sample_pots) begin
                    n_crossed = '0;
                end else begin
                    n_crossed = r_crossed | hits;
                    if ((hits & r_latch) != '0) begin
                        n_nmi = 1'b1;
                    end
                end
                if (n_phase == '0) begin
                    n_irq = 1'b1;
                end
            end
            pstio_pkg::OP_READ: begin
                if (i_address[13:8] == 6'h08) begin
                    n_read_data = {sw_val[i_address[2:0]], 7'b0};
                end else if (i_address[13:11] == 3'b010) begin
                    n_read_data = misc_val ^ pstio_pkg::READ_XOR;
                end
            end
            pstio_pkg::OP_WRITE: begin
                if (i_address == pstio_pkg::ADDR_POT_LATCH) begin
                    n_latch = i_write_data[pstio_pkg::NUM_POTS-1:0];
                    n_nmi   = 1'b0;
                end else if (i_address[13:8] == 6'h1c) begin
                    n_irq = 1'b0;
                end
            end
            default: begin
                // Unused op code: the state holds and the read byte is zero.
            end
        endcase
    end

    // Configuration writes; an index past the list is ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rounds     <= 2'd1;
            r_coinage    <= 2'd1;
            r_round_time <= 8'd92;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                pstio_pkg::CFG_ROUNDS:  r_rounds     <= i_cfg_data[1:0];
                pstio_pkg::CFG_COINAGE: r_coinage    <= i_cfg_data[1:0];
                pstio_pkg::CFG_ROUND_T: r_round_time <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // State moves only on an accepted request; the line, IRQ and NMI ports
    // read these registers directly, which always match the result held in
    // the result register because both load at the same edge.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line    <= pstio_pkg::LINE_LAST;
            r_phase   <= pstio_pkg::PHASE_RST;
            r_crossed <= '0;
            r_latch   <= '0;
            r_irq     <= 1'b0;
            r_nmi     <= 1'b0;
            for (int i = 0; i < pstio_pkg::NUM_POTS; i++) begin
                r_pot[i] <= '0;
            end
        end else if (accept) begin
            r_crossed <= n_crossed;
            r_latch   <= n_latch;
            r_irq     <= n_irq;
            r_nmi     <= n_nmi;
            if (i_op == pstio_pkg::OP_TICK) begin
                r_line  <= n_line;
                r_phase <= n_phase;
                if (sample_pots) begin
                    for (int i = 0; i < pstio_pkg::NUM_POTS; i++) begin
                        r_pot[i] <= pot_in[i];
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_read_data <= n_read_data;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_read_data = r_read_data;
    assign o_irq_level = r_irq;
    assign o_nmi_level = r_nmi;
    assign o_line_now  = r_line;

endmodule

FILE: rtl/core/pot_scanline_timer_io_chk.sv
// ----------------------------------------------------------------------------
// pot_scanline_timer_io_props
// Port-level checks of the scanline pot timer block, bound to the top level.
// ----------------------------------------------------------------------------
`include "pot_scanline_timer_io_assert.svh"

module pot_scanline_timer_io_props (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_stall,
    input logic [1:0]  i_op,
    input logic [13:0] i_address,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [7:0]  o_read_data,
    input logic        o_nmi_level,
    input logic [8:0]  o_line_now
);

    logic                         acc;
    logic                         tick_acc;
    logic                         other_acc;
    logic                         latch_acc;
    logic                         held;
    logic                         reset_ok;
    logic [pstio_pkg::LINE_W-1:0] line_after;

    assign acc        = i_in_valid & ~o_in_stall;
    assign tick_acc   = acc & (i_op == pstio_pkg::OP_TICK);
    assign other_acc  = acc & (i_op != pstio_pkg::OP_READ);
    assign latch_acc  = acc & (i_op == pstio_pkg::OP_WRITE) &
                        (i_address == pstio_pkg::ADDR_POT_LATCH);
    assign held       = o_out_valid & i_out_stall;
    assign reset_ok   = !o_out_valid && (o_line_now == pstio_pkg::LINE_LAST);
    assign line_after = (o_line_now == pstio_pkg::LINE_LAST) ? '0 : o_line_now + 9'd1;

    `PSTIO_ASSERT_RST(a_reset_state, i_clk, !i_rst_n |=> reset_ok, "reset state wrong")

    `PSTIO_ASSERT(a_hold, i_clk, i_rst_n, held |=> o_out_valid && $stable(o_read_data), "result moved")

    `PSTIO_ASSERT(a_zero, i_clk, i_rst_n, other_acc |=> o_read_data == 8'd0, "data not zero")

    `PSTIO_ASSERT(a_tick, i_clk, i_rst_n, tick_acc |=> o_line_now == $past(line_after), "line step")

    `PSTIO_ASSERT(a_nmi_clear, i_clk, i_rst_n, latch_acc |=> !o_nmi_level, "NMI left raised")

endmodule

bind pot_scanline_timer_io pot_scanline_timer_io_props u_chk (.*);

FILE: test/pot_scanline_timer_io_chk.sv
// ----------------------------------------------------------------------------
// pot_scanline_timer_io_chk
// Watches the request and result channels of the scanline pot timer, keeps
// its own copy of the line, pot and interrupt state, and compares every
// result with the one expected for the oldest outstanding request.
// ----------------------------------------------------------------------------
module pot_scanline_timer_io_chk (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [7:0]  i_cfg_data,
    input  logic        i_in_valid,
    input  logic        i_in_stall,
    input  logic [1:0]  i_op,
    input  logic [13:0] i_address,
    input  logic [7:0]  i_write_data,
    input  logic [7:0]  i_stick_a_x,
    input  logic [7:0]  i_stick_a_y,
    input  logic [7:0]  i_paddle_a,
    input  logic [7:0]  i_stick_b_x,
    input  logic [7:0]  i_stick_b_y,
    input  logic [7:0]  i_paddle_b,
    input  logic [7:0]  i_switches,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  logic [7:0]  i_read_data,
    input  logic        i_irq_level,
    input  logic        i_nmi_level,
    input  logic [8:0]  i_line_now,
    output int          o_fail_count,
    output int          o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [13:0] SW_BASE      = 14'h0800;
    localparam logic [13:0] SW_TOP       = 14'h08ff;
    localparam logic [13:0] MISC_BASE    = 14'h1000;
    localparam logic [13:0] MISC_TOP     = 14'h17ff;
    localparam logic [13:0] IRQ_ACK_BASE = 14'h1c00;
    localparam logic [13:0] IRQ_ACK_TOP  = 14'h1cff;
    localparam int          REPORT_MAX   = 10;

    typedef struct packed {
        logic [7:0]                   read_data;
        logic                         irq;
        logic                         nmi;
        logic [pstio_pkg::LINE_W-1:0] line;
    } scan_result_t;

    // Shadow of the block's state and settings.
    logic [pstio_pkg::LINE_W-1:0]             line_q;
    logic [pstio_pkg::NUM_POTS-1:0][7:0]      pot_q;
    logic [pstio_pkg::NUM_POTS-1:0]           crossed_q;
    logic [pstio_pkg::NUM_POTS-1:0]           latch_q;
    logic                                     irq_q;
    logic                                     nmi_q;
    logic [1:0]                               rounds_q;
    logic [1:0]                               coinage_q;
    logic [7:0]                               round_time_q;

    scan_result_t expected_results[$];
    scan_result_t want;
    scan_result_t got;

    task automatic predict_scan_result(
        input  logic [1:0]                          op,
        input  logic [13:0]                         addr,
        input  logic [7:0]                          wdata,
        input  logic [pstio_pkg::NUM_POTS-1:0][7:0] pots,
        input  logic [7:0]                          switches,
        output scan_result_t                        res
    );
        logic [pstio_pkg::LINE_W-1:0] nxt;
        logic [7:0]                   sw;
        logic [7:0]                   misc;
        res.read_data = '0;
        case (op)
            pstio_pkg::OP_TICK: begin
                nxt = line_q + 1'b1;
                if (nxt >= pstio_pkg::LINES_PER_FRAME)
                    nxt = '0;
                line_q = nxt;
                if (nxt == 0) begin
                    pot_q     = pots;
                    crossed_q = '0;
                end else if (nxt < 256) begin
                    for (int p = 0; p < pstio_pkg::NUM_POTS; p++) begin
                        if (pot_q[p] == nxt) begin
                            crossed_q[p] = 1'b1;
                            if (latch_q[p])
                                nmi_q = 1'b1;
                        end
                    end
                end
                if (nxt % pstio_pkg::IRQ_LINE_STEP == 0)
                    irq_q = 1'b1;
            end
            pstio_pkg::OP_READ: begin
                if (addr >= SW_BASE && addr <= SW_TOP) begin
                    // Bit 1 also carries the round timer flag.
                    sw = switches;
                    if (line_q > round_time_q)
                        sw[1] = 1'b1;
                    res.read_data = {sw[addr[2:0]], 7'b0};
                end else if (addr >= MISC_BASE && addr <= MISC_TOP) begin
                    case (addr[1:0])
                        pstio_pkg::MISC_POTS:   misc = {2'b0, crossed_q & latch_q};
                        pstio_pkg::MISC_LINE:   misc = line_q[7:0];
                        pstio_pkg::MISC_ROUNDS: misc = {6'b0, rounds_q};
                        default:                misc = {6'b0, coinage_q};
                    endcase
                    res.read_data = misc ^ pstio_pkg::READ_XOR;
                end
            end
            pstio_pkg::OP_WRITE: begin
                if (addr == pstio_pkg::ADDR_POT_LATCH) begin
                    latch_q = wdata[pstio_pkg::NUM_POTS-1:0];
                    nmi_q   = 1'b0;
                end else if (addr >= IRQ_ACK_BASE && addr <= IRQ_ACK_TOP) begin
                    irq_q = 1'b0;
                end
            end
            default: ;
        endcase
        res.irq  = irq_q;
        res.nmi  = nmi_q;
        res.line = line_q;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            line_q       = pstio_pkg::LINE_LAST;
            pot_q        = '0;
            crossed_q    = '0;
            latch_q      = '0;
            irq_q        = 1'b0;
            nmi_q        = 1'b0;
            rounds_q     = 2'd1;
            coinage_q    = 2'd1;
            round_time_q = 8'd92;
            expected_results.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    pstio_pkg::CFG_ROUNDS:  rounds_q     = i_cfg_data[1:0];
                    pstio_pkg::CFG_COINAGE: coinage_q    = i_cfg_data[1:0];
                    pstio_pkg::CFG_ROUND_T: round_time_q = i_cfg_data;
                    default: ;
                endcase
            end

            if (i_out_valid && !i_out_stall) begin
                got = '{i_read_data, i_irq_level, i_nmi_level, i_line_now};
                if (expected_results.size() == 0) begin
                    o_fail_count++;
                    if (o_fail_count <= REPORT_MAX)
                        $display("unexpected result: read_data %02h irq %0d nmi %0d line %0d",
                                 got.read_data, got.irq, got.nmi, got.line);
                end else begin
                    want = expected_results.pop_front();
                    if (got.read_data !== want.read_data || got.irq !== want.irq ||
                        got.nmi !== want.nmi || got.line !== want.line) begin
                        o_fail_count++;
                        if (o_fail_count <= REPORT_MAX)
                            $display("mismatch: expected %02h %0d %0d %0d, actual %02h %0d %0d %0d",
                                     want.read_data, want.irq, want.nmi, want.line,
                                     got.read_data, got.irq, got.nmi, got.line);
                    end
                end
            end

            if (i_in_valid && !i_in_stall) begin
                predict_scan_result(i_op, i_address, i_write_data,
                                    {i_paddle_b, i_stick_b_y, i_stick_b_x,
                                     i_paddle_a, i_stick_a_y, i_stick_a_x},
                                    i_switches, want);
                expected_results.push_back(want);
            end
        end
        o_pending = expected_results.size();
    end

endmodule

FILE: test/pot_scanline_timer_io_tb.sv
// ----------------------------------------------------------------------------
// pot_scanline_timer_io_tb
// Drives bus reads, bus writes and scanline ticks into the pot timer block
// under random sender gaps and receiver stalls, over several DIP and round
// timer settings; the checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module pot_scanline_timer_io_tb;
    timeunit 1ns;
    timeprecision 1ps;

    // Address map used to aim the stimulus at the decoded windows.
    localparam logic [13:0] SW_BASE      = 14'h0800;
    localparam logic [13:0] SW_TOP       = 14'h08ff;
    localparam logic [13:0] MISC_BASE    = 14'h1000;
    localparam logic [13:0] MISC_TOP     = 14'h17ff;
    localparam logic [13:0] IRQ_ACK_BASE = 14'h1c00;
    localparam logic [13:0] IRQ_ACK_TOP  = 14'h1cff;

    // The op code and register index the block has no use for.
    localparam logic [1:0] OP_SPARE  = 2'd3;
    localparam logic [1:0] CFG_SPARE = 2'd3;

    localparam int PHASES           = 5;
    localparam int RANDOM_PER_PHASE = 360;

    typedef struct packed {
        logic [1:0]                          op;
        logic [13:0]                         addr;
        logic [7:0]                          wdata;
        logic [pstio_pkg::NUM_POTS-1:0][7:0] pots;
        logic [7:0]                          switches;
    } bus_request_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_index;
    logic [7:0]  i_cfg_data;
    logic        i_in_valid;
    logic        o_in_stall;
    logic [1:0]  i_op;
    logic [13:0] i_address;
    logic [7:0]  i_write_data;
    logic [7:0]  i_stick_a_x;
    logic [7:0]  i_stick_a_y;
    logic [7:0]  i_paddle_a;
    logic [7:0]  i_stick_b_x;
    logic [7:0]  i_stick_b_y;
    logic [7:0]  i_paddle_b;
    logic [7:0]  i_switches;
    logic        o_out_valid;
    logic        i_out_stall;
    logic [7:0]  o_read_data;
    logic        o_irq_level;
    logic        o_nmi_level;
    logic [8:0]  o_line_now;

    int fail_count;
    int pending;

    // When set, neither side inserts idle cycles.
    bit quiet = 1'b0;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    pot_scanline_timer_io dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_op         (i_op),
        .i_address    (i_address),
        .i_write_data (i_write_data),
        .i_stick_a_x  (i_stick_a_x),
        .i_stick_a_y  (i_stick_a_y),
        .i_paddle_a   (i_paddle_a),
        .i_stick_b_x  (i_stick_b_x),
        .i_stick_b_y  (i_stick_b_y),
        .i_paddle_b   (i_paddle_b),
        .i_switches   (i_switches),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_read_data  (o_read_data),
        .o_irq_level  (o_irq_level),
        .o_nmi_level  (o_nmi_level),
        .o_line_now   (o_line_now)
    );

    pot_scanline_timer_io_chk u_chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .i_in_stall   (o_in_stall),
        .i_op         (i_op),
        .i_address    (i_address),
        .i_write_data (i_write_data),
        .i_stick_a_x  (i_stick_a_x),
        .i_stick_a_y  (i_stick_a_y),
        .i_paddle_a   (i_paddle_a),
        .i_stick_b_x  (i_stick_b_x),
        .i_stick_b_y  (i_stick_b_y),
        .i_paddle_b   (i_paddle_b),
        .i_switches   (i_switches),
        .i_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .i_read_data  (o_read_data),
        .i_irq_level  (o_irq_level),
        .i_nmi_level  (o_nmi_level),
        .i_line_now   (o_line_now),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // Builds a request with random pot and switch values. Pot zero shows up
    // often on purpose, since a zero sample must never mark a crossing.
    function automatic bus_request_t make_request(
        input logic [1:0]  op,
        input logic [13:0] addr,
        input logic [7:0]  wdata
    );
        bus_request_t r;
        r.op    = op;
        r.addr  = addr;
        r.wdata = wdata;
        for (int p = 0; p < pstio_pkg::NUM_POTS; p++)
            r.pots[p] = ($urandom_range(0, 7) == 0) ? 8'd0 : 8'($urandom_range(0, 255));
        r.switches = 8'($urandom);
        return r;
    endfunction

    // Mostly scanline ticks so that whole frames go by, with reads and writes
    // aimed at the decoded windows and a share of fully random addresses.
    function automatic bus_request_t random_request();
        int          kind;
        int          pick;
        logic [13:0] addr;
        kind = $urandom_range(0, 99);
        pick = $urandom_range(0, 99);
        addr = 14'($urandom);
        if (kind < 60)
            return make_request(pstio_pkg::OP_TICK, addr, 8'($urandom));
        if (kind < 82) begin
            if (pick < 40)
                addr = SW_BASE + 14'($urandom_range(0, 255));
            else if (pick < 85)
                addr = MISC_BASE + 14'($urandom_range(0, 2047));
            return make_request(pstio_pkg::OP_READ, addr, 8'($urandom));
        end
        if (kind < 97) begin
            if (pick < 40)
                addr = pstio_pkg::ADDR_POT_LATCH;
            else if (pick < 80)
                addr = IRQ_ACK_BASE + 14'($urandom_range(0, 255));
            return make_request(pstio_pkg::OP_WRITE, addr, 8'($urandom));
        end
        return make_request(OP_SPARE, addr, 8'($urandom));
    endfunction

    // Presents one request and returns at the edge where it was taken.
    // The payload is held steady for as long as the block stalls.
    task automatic send_request(input bus_request_t r);
        if (!quiet && $urandom_range(0, 4) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_op         <= r.op;
        i_address    <= r.addr;
        i_write_data <= r.wdata;
        i_stick_a_x  <= r.pots[0];
        i_stick_a_y  <= r.pots[1];
        i_paddle_a   <= r.pots[2];
        i_stick_b_x  <= r.pots[3];
        i_stick_b_y  <= r.pots[4];
        i_paddle_b   <= r.pots[5];
        i_switches   <= r.switches;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    task automatic send_op(input logic [1:0] op, input logic [13:0] addr,
                           input logic [7:0] wdata);
        send_request(make_request(op, addr, wdata));
    endtask

    // Waits until every result has come back, then lets the
    // pipeline settle. The pending count is read on the falling edge so it
    // is never looked at while the checker is updating it.
    task automatic drain();
        i_in_valid <= 1'b0;
        do @(negedge i_clk); while (pending != 0);
        repeat (3) @(posedge i_clk);
    endtask

    // Writes all registers back to back. The spare index must be ignored.
    // The write enable is only lowered after the last one, so it never sees
    // two assignments in one step.
    task automatic load_settings(input logic [7:0] rounds, input logic [7:0] coinage,
                                 input logic [7:0] rtime);
        logic [1:0] idx [4];
        logic [7:0] val [4];
        idx = '{pstio_pkg::CFG_ROUNDS, pstio_pkg::CFG_COINAGE, pstio_pkg::CFG_ROUND_T,
                CFG_SPARE};
        val = '{rounds, coinage, rtime, 8'($urandom)};
        for (int k = 0; k < 4; k++) begin
            i_cfg_we    <= 1'b1;
            i_cfg_index <= idx[k];
            i_cfg_data  <= val[k];
            @(posedge i_clk);
        end
        i_cfg_we <= 1'b0;
    endtask

    // Directed requests run right after reset with the default settings.
    task automatic run_directed();
        bus_request_t r;
        // Before the first tick the line still reads 261, which is past the
        // default round time, so the timer flag is up on switch bit 1.
        send_op(pstio_pkg::OP_READ, MISC_BASE + 14'(pstio_pkg::MISC_LINE), 8'h00);
        r = make_request(pstio_pkg::OP_READ, SW_BASE + 14'd1, 8'h00);
        r.switches = 8'h00;
        send_request(r);
        // The first tick wraps to line 0, samples the pots and raises IRQ.
        r = make_request(pstio_pkg::OP_TICK, 14'h0000, 8'h00);
        r.pots = {8'd64, 8'd128, 8'd2, 8'd255, 8'd1, 8'd0};
        send_request(r);
        // Enable every pot latch, with the upper data bits set as well.
        send_op(pstio_pkg::OP_WRITE, pstio_pkg::ADDR_POT_LATCH, 8'hff);
        // Line 1 matches the second pot and raises NMI.
        send_op(pstio_pkg::OP_TICK, 14'h3fff, 8'h00);
        send_op(pstio_pkg::OP_WRITE, IRQ_ACK_BASE, 8'h00);
        send_op(pstio_pkg::OP_TICK, 14'h0000, 8'hff);
        send_op(pstio_pkg::OP_READ, MISC_BASE + 14'(pstio_pkg::MISC_POTS), 8'h00);
        // At line 2 the timer flag is down again.
        r = make_request(pstio_pkg::OP_READ, SW_BASE + 14'd1, 8'h00);
        r.switches = 8'h00;
        send_request(r);
        send_op(pstio_pkg::OP_READ, MISC_BASE + 14'(pstio_pkg::MISC_ROUNDS), 8'h00);
        send_op(pstio_pkg::OP_READ, MISC_TOP, 8'h00);
        r = make_request(pstio_pkg::OP_READ, SW_BASE, 8'h00);
        r.switches = 8'hff;
        send_request(r);
        r = make_request(pstio_pkg::OP_READ, SW_TOP, 8'h00);
        r.switches = 8'h80;
        send_request(r);
        // Just outside the windows: unmapped reads and ignored writes; then the top IRQ ack address.
        send_op(pstio_pkg::OP_READ, SW_BASE - 14'd1, 8'h00);
        send_op(pstio_pkg::OP_READ, SW_TOP + 14'd1, 8'h00);
        send_op(pstio_pkg::OP_READ, MISC_TOP + 14'd1, 8'h00);
        send_op(pstio_pkg::OP_READ, 14'h3fff, 8'h00);
        send_op(pstio_pkg::OP_WRITE, pstio_pkg::ADDR_POT_LATCH + 14'd1, 8'hff);
        send_op(pstio_pkg::OP_WRITE, IRQ_ACK_BASE - 14'd1, 8'h00);
        send_op(pstio_pkg::OP_WRITE, IRQ_ACK_TOP + 14'd1, 8'h00);
        send_op(pstio_pkg::OP_WRITE, IRQ_ACK_TOP, 8'h00);
        // The spare op code must leave all state alone.
        send_op(OP_SPARE, pstio_pkg::ADDR_POT_LATCH, 8'hff);
        // Latch write with only the unused bits set clears the latch and NMI.
        send_op(pstio_pkg::OP_WRITE, pstio_pkg::ADDR_POT_LATCH, 8'hc0);
    endtask

    // Result side: the receiver stalls in random bursts until the quiet part.
    initial begin
        i_out_stall <= 1'b0;
        @(posedge i_clk);
        forever begin
            if (!quiet && $urandom_range(0, 3) == 0) begin
                i_out_stall <= 1'b1;
                repeat ($urandom_range(1, 13)) @(posedge i_clk);
                i_out_stall <= 1'b0;
            end
            @(posedge i_clk);
        end
    end

    // Request side and verdict.
    initial begin
        i_rst_n      <= 1'b0;
        i_cfg_we     <= 1'b0;
        i_cfg_index  <= pstio_pkg::CFG_ROUNDS;
        i_cfg_data   <= 8'h00;
        i_in_valid   <= 1'b0;
        i_op         <= pstio_pkg::OP_TICK;
        i_address    <= '0;
        i_write_data <= '0;
        i_stick_a_x  <= '0;
        i_stick_a_y  <= '0;
        i_paddle_a   <= '0;
        i_stick_b_x  <= '0;
        i_stick_b_y  <= '0;
        i_paddle_b   <= '0;
        i_switches   <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        run_directed();
        for (int phase = 0; phase < PHASES; phase++) begin
            // Settings only change while the block has nothing in flight.
            // The first phase keeps the reset values; the next two hit the
            // extremes, then come values with bits above the register width,
            // and last a random setting with no idling on either side.
            if (phase > 0) begin
                drain();
                case (phase)
                    1: load_settings(8'h00, 8'h03, 8'h00);
                    2: load_settings(8'h03, 8'h00, 8'hff);
                    3: load_settings(8'hfe, 8'hfd, 8'h80);
                    default: load_settings(8'($urandom), 8'($urandom), 8'($urandom));
                endcase
            end
            quiet = (phase == PHASES - 1);
            repeat (RANDOM_PER_PHASE) send_request(random_request());
        end
        drain();

        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // Hard stop well beyond the slowest legal run.
    initial begin
        #1_000_000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule

FILE: pot_scanline_timer_io.f
+incdir+rtl/core
rtl/core/pstio_pkg.sv
rtl/core/pot_scanline_timer_io.sv
rtl/core/pot_scanline_timer_io_chk.sv
test/pot_scanline_timer_io_chk.sv
test/pot_scanline_timer_io_tb.sv
